/* rtl/freq_meter_display_pages_assert.svh */
// Assertion macros used by the display page top module.
`ifndef FREQ_METER_DISPLAY_PAGES_ASSERT_SVH
`define FREQ_METER_DISPLAY_PAGES_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define FMDP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fmdp assertion failed");

// The consequent must hold at the same edge as the antecedent.
`define FMDP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmdp assertion failed");

`endif

/* rtl/fmdp_pkg.sv */
`timescale 1ns / 1ps

package fmdp_pkg;

  typedef logic [4:0] cell_t;
  typedef logic [3:0] digit_t;
  typedef digit_t [4:0] bcd5_t;
  typedef logic [7:0][7:0] seg_row_t;

  localparam cell_t G_DASH  = 5'd10;
  localparam cell_t G_F     = 5'd11;
  localparam cell_t G_P     = 5'd12;
  localparam cell_t G_H     = 5'd13;
  localparam cell_t G_A     = 5'd14;
  localparam cell_t G_BLANK = 5'd15;
  localparam cell_t G_L     = 5'd16;
  localparam cell_t G_ONE   = 5'd1;
  localparam cell_t G_TWO   = 5'd2;
  localparam cell_t G_ZERO  = 5'd0;

  localparam logic [1:0] MODE_FREQ  = 2'd0;
  localparam logic [1:0] MODE_PARAM = 2'd1;
  localparam logic [1:0] MODE_TIME  = 2'd2;
  localparam logic [1:0] MODE_MAX   = 2'd3;

  localparam logic [16:0] FREQ_SAT  = 17'd99999;
  localparam logic [13:0] PARAM_SAT = 14'd9999;
  localparam logic [10:0] CALI_SAT  = 11'd999;

  typedef struct packed {
    logic [1:0]         mode;
    logic               sub_page;
    logic signed [17:0] freq_now;
    logic [13:0]        param_value;
    logic signed [10:0] cali_value;
    logic [23:0]        time_digits;
  } item_t;

  typedef struct packed {
    logic        capture;
    logic [16:0] new_max;
  } max_upd_t;

  // One decimal digit: count how many multiples of unit fit, then subtract.
  function automatic logic [20:0] dec_step(input logic [16:0] rem, input logic [16:0] unit);
    logic [3:0]  d;
    logic [20:0] sub;
    logic [20:0] cand;
    int          j;
    d    = '0;
    sub  = '0;
    cand = '0;
    for (j = 1; j < 10; j++) begin
      cand = unit * 4'(j);
      if ({4'd0, rem} >= cand) begin
        d   = 4'(j);
        sub = cand;
      end
    end
    return {d, rem - sub[16:0]};
  endfunction

  function automatic bcd5_t to_bcd5(input logic [16:0] v);
    logic [20:0] s4;
    logic [20:0] s3;
    logic [20:0] s2;
    logic [20:0] s1;
    bcd5_t       r;
    s4   = dec_step(v, 17'd10000);
    s3   = dec_step(s4[16:0], 17'd1000);
    s2   = dec_step(s3[16:0], 17'd100);
    s1   = dec_step(s2[16:0], 17'd10);
    r[4] = s4[20:17];
    r[3] = s3[20:17];
    r[2] = s2[20:17];
    r[1] = s1[20:17];
    r[0] = s1[3:0];
    return r;
  endfunction

  function automatic logic [7:0] glyph(input cell_t c);
    logic [7:0] g;
    case (c)
      5'd0:    g = 8'hC0;
      5'd1:    g = 8'hF9;
      5'd2:    g = 8'hA4;
      5'd3:    g = 8'hB0;
      5'd4:    g = 8'h99;
      5'd5:    g = 8'h92;
      5'd6:    g = 8'h82;
      5'd7:    g = 8'hF8;
      5'd8:    g = 8'h80;
      5'd9:    g = 8'h90;
      G_DASH:  g = 8'hBF;
      G_F:     g = 8'h8E;
      G_P:     g = 8'h8C;
      G_H:     g = 8'h89;
      G_A:     g = 8'h88;
      G_L:     g = 8'hC7;
      default: g = 8'hFF;
    endcase
    return g;
  endfunction

endpackage

/* rtl/fmdp_in_reg.sv */
`timescale 1ns / 1ps

module fmdp_in_reg import fmdp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  take,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = accept || (valid_r && !take);
    item_nxt  = accept ? in_item : item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* rtl/fmdp_page.sv */
`timescale 1ns / 1ps

module fmdp_page import fmdp_pkg::*; (
  input  item_t       item,
  input  logic [16:0] max_freq,
  input  logic [23:0] time_of_max,
  output max_upd_t    upd,
  output seg_row_t    seg
);

  logic        freq_neg;
  logic [16:0] f_sat;
  logic [16:0] max_shown;
  logic [13:0] param_sat;
  logic        cali_neg;
  logic [10:0] cali_mag;
  logic [10:0] mag_sat;
  logic [16:0] conv_in;
  bcd5_t       d;
  cell_t       c [8];
  cell_t       five [5];

  always_comb begin
    freq_neg = item.freq_now[17];
    if (freq_neg) begin
      f_sat = '0;
    end else if (item.freq_now[16:0] > FREQ_SAT) begin
      f_sat = FREQ_SAT;
    end else begin
      f_sat = item.freq_now[16:0];
    end
    upd.capture = (item.mode == MODE_MAX) && !item.sub_page && (f_sat > max_freq);
    upd.new_max = f_sat;
    max_shown   = upd.capture ? f_sat : max_freq;

    param_sat = (item.param_value > PARAM_SAT) ? PARAM_SAT : item.param_value;
    cali_neg  = item.cali_value[10];
    cali_mag  = cali_neg ? (~item.cali_value + 11'd1) : item.cali_value;
    mag_sat   = (cali_mag > CALI_SAT) ? CALI_SAT : cali_mag;

    case (item.mode)
      MODE_FREQ:  conv_in = f_sat;
      MODE_PARAM: conv_in = item.sub_page ? {6'd0, mag_sat} : {3'd0, param_sat};
      MODE_MAX:   conv_in = max_shown;
      default:    conv_in = '0;
    endcase
  end

  assign d = to_bcd5(conv_in);

  always_comb begin
    five[0] = (d[4] == '0) ? G_BLANK : {1'b0, d[4]};
    five[1] = (d[4] == '0 && d[3] == '0) ? G_BLANK : {1'b0, d[3]};
    five[2] = (d[4] == '0 && d[3] == '0 && d[2] == '0) ? G_BLANK : {1'b0, d[2]};
    five[3] = (d[4] == '0 && d[3] == '0 && d[2] == '0 && d[1] == '0) ? G_BLANK
                                                                      : {1'b0, d[1]};
    five[4] = {1'b0, d[0]};
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      c[i] = G_BLANK;
    end
    case (item.mode)
      MODE_FREQ: begin
        c[0] = G_F;
        if (freq_neg) begin
          c[6] = G_L;
          c[7] = G_L;
        end else begin
          for (int i = 0; i < 5; i++) begin
            c[3 + i] = five[i];
          end
        end
      end
      MODE_PARAM: begin
        c[0] = G_P;
        if (!item.sub_page) begin
          c[1] = G_ONE;
          c[4] = {1'b0, d[3]};
          c[5] = {1'b0, d[2]};
          c[6] = {1'b0, d[1]};
          c[7] = {1'b0, d[0]};
        end else begin
          c[1] = G_TWO;
          if (item.cali_value == '0) begin
            c[7] = G_ZERO;
          end else begin
            c[4] = cali_neg ? G_DASH : G_BLANK;
            c[5] = {1'b0, d[2]};
            c[6] = {1'b0, d[1]};
            c[7] = {1'b0, d[0]};
          end
        end
      end
      MODE_TIME: begin
        c[0] = {1'b0, item.time_digits[23:20]};
        c[1] = {1'b0, item.time_digits[19:16]};
        c[2] = G_DASH;
        c[3] = {1'b0, item.time_digits[15:12]};
        c[4] = {1'b0, item.time_digits[11:8]};
        c[5] = G_DASH;
        c[6] = {1'b0, item.time_digits[7:4]};
        c[7] = {1'b0, item.time_digits[3:0]};
      end
      default: begin
        c[0] = G_H;
        if (!item.sub_page) begin
          c[1] = G_F;
          for (int i = 0; i < 5; i++) begin
            c[3 + i] = five[i];
          end
        end else begin
          c[1] = G_A;
          for (int i = 0; i < 6; i++) begin
            c[2 + i] = {1'b0, time_of_max[23 - 4 * i -: 4]};
          end
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      seg[i] = glyph(c[i]);
    end
  end

endmodule

/* rtl/freq_meter_display_pages.sv */
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_stall   mode, sub_page, freq_now, param_value, cali_value,
//                                 time_digits
// out       out_valid / out_stall seg0 .. seg7, active-low segment patterns
//
// An accepted item passes through the input register, then the result register.
// One item can be accepted in every cycle while the result is not stalled; the decimal conversion is combinational.
// Reset clears both valid flags, the stored maximum frequency and its time.
// A stalled result holds; the input stalls only when its register is full and cannot move.
`include "freq_meter_display_pages_assert.svh"

module freq_meter_display_pages import fmdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic               in_sub_page,
  input  logic signed [17:0] in_freq_now,
  input  logic [13:0]        in_param_value,
  input  logic signed [10:0] in_cali_value,
  input  logic [23:0]        in_time_digits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_seg0,
  output logic [7:0]         out_seg1,
  output logic [7:0]         out_seg2,
  output logic [7:0]         out_seg3,
  output logic [7:0]         out_seg4,
  output logic [7:0]         out_seg5,
  output logic [7:0]         out_seg6,
  output logic [7:0]         out_seg7
);

  item_t       in_item;
  item_t       s1_item;
  logic        s1_valid;
  logic        take;
  logic        fire;
  max_upd_t    upd;
  seg_row_t    seg;

  logic        out_valid_r;
  logic        out_valid_nxt;
  seg_row_t    seg_r;
  seg_row_t    seg_nxt;
  logic [16:0] max_freq_r;
  logic [16:0] max_freq_nxt;
  logic [23:0] time_of_max_r;
  logic [23:0] time_of_max_nxt;

  always_comb begin
    in_item.mode        = in_mode;
    in_item.sub_page    = in_sub_page;
    in_item.freq_now    = in_freq_now;
    in_item.param_value = in_param_value;
    in_item.cali_value  = in_cali_value;
    in_item.time_digits = in_time_digits;
  end

  assign take = !out_valid_r || !out_stall;
  assign fire = s1_valid && take;

  fmdp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  fmdp_page u_page (
    .item        (s1_item),
    .max_freq    (max_freq_r),
    .time_of_max (time_of_max_r),
    .upd         (upd),
    .seg         (seg)
  );

  always_comb begin
    out_valid_nxt   = fire || (out_valid_r && out_stall);
    seg_nxt         = fire ? seg : seg_r;
    max_freq_nxt    = max_freq_r;
    time_of_max_nxt = time_of_max_r;
    if (fire && upd.capture) begin
      max_freq_nxt    = upd.new_max;
      time_of_max_nxt = s1_item.time_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      max_freq_r    <= '0;
      time_of_max_r <= '0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      max_freq_r    <= max_freq_nxt;
      time_of_max_r <= time_of_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_seg0  = seg_r[0];
  assign out_seg1  = seg_r[1];
  assign out_seg2  = seg_r[2];
  assign out_seg3  = seg_r[3];
  assign out_seg4  = seg_r[4];
  assign out_seg5  = seg_r[5];
  assign out_seg6  = seg_r[6];
  assign out_seg7  = seg_r[7];

  `FMDP_ASSERT_IMPLY(a_no_stall_when_free, !out_stall, !in_stall)
  `FMDP_ASSERT_ALWAYS(a_max_saturated, max_freq_r <= FREQ_SAT)
  `FMDP_ASSERT_IMPLY(a_max_monotonic, $past(rst_n), max_freq_r >= $past(max_freq_r))
  `FMDP_ASSERT_IMPLY(a_result_from_stage, $rose(out_valid_r), $past(s1_valid))

endmodule
